FILE: design/bolt_window_controller_macros.svh
// Assertion macros shared by the window controller RTL.
`ifndef BOLT_WINDOW_CONTROLLER_MACROS_SVH
`define BOLT_WINDOW_CONTROLLER_MACROS_SVH

// Implication checked on every rising clock edge, skipped while in reset.
`define BWC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising clock edge, skipped while in reset.
`define BWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bwc_pkg.sv
// ----------------------------------------------------------------------------
// bwc_pkg
// Types and constants for the congestion window controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bwc_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_SENT     = 2'd0;
  localparam logic [1:0] MODE_FEEDBACK = 2'd1;
  localparam logic [1:0] MODE_ACK      = 2'd2;
  localparam logic [1:0] MODE_NOP      = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_SEGMENT_SIZE   = 2'd0;
  localparam logic [1:0] REG_BIT_RATE       = 2'd1;
  localparam logic [1:0] REG_INITIAL_WINDOW = 2'd2;

  localparam int CFG_W   = 39;
  localparam int DVD_W   = 72;
  localparam int DVS_W   = 64;
  localparam int CNT_W   = 7;
  localparam int NOPS    = 6;
  localparam int OP_W    = 3;

  // Nanoseconds per second times bits per byte
  localparam logic [32:0] NS8 = 33'd8000000000;

  // Division steps of the feedback sequence
  localparam logic [OP_W-1:0] OP_DW_S    = 3'd0;  // ceil(D*W / S)
  localparam logic [OP_W-1:0] OP_Q_RTT   = 3'd1;  // ceil(q / rtt)
  localparam logic [OP_W-1:0] OP_DL_NS   = 3'd2;  // ceil(D*L / 8e9)
  localparam logic [OP_W-1:0] OP_Q_S     = 3'd3;  // ceil(q / S)
  localparam logic [OP_W-1:0] OP_RTT_T   = 3'd4;  // floor(rtt / target)
  localparam logic [OP_W-1:0] OP_SL_LINK = 3'd5;  // floor(S*8e9 / L)

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MUL2,
    S_LOAD,
    S_DIV,
    S_STORE,
    S_APPLY,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now_ns;
    logic [31:0] seq_num;
    logic [15:0] segment_bytes;
    logic [31:0] drain_time_ns;
    logic [63:0] tx_stamp_ns;
    logic        inc_flag;
  } in_item_t;

  typedef struct packed {
    logic        request_inc;
    logic [31:0] window_bytes;
    logic        decreased;
  } out_item_t;

endpackage

FILE: design/bolt_window_controller.sv
// ----------------------------------------------------------------------------
// bolt_window_controller
// Congestion window controller driven by switch feedback and ack flags.
// ----------------------------------------------------------------------------
// Sent-segment, ack and no-op items: the item is captured in idle, applied, then
//   registered into out_data in the respond state; the next item is accepted back in idle.
// Feedback items: the multiply states MUL and MUL2, six passes of the shared restoring
//   divider, apply and respond; no new item is accepted until back in idle.
// A result held by out_ready low stalls the input until it is taken.
// Reset (rst, synchronous): registers to defaults, window 14480, state idle.
`timescale 1ns / 1ps

`include "bolt_window_controller_macros.svh"

module bolt_window_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bwc_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output bwc_pkg::out_item_t        out_data,
  input  logic                      wr_en,
  input  logic [1:0]                wr_index,
  input  logic [bwc_pkg::CFG_W-1:0] wr_data
);

  // Configuration and controller state
  logic [15:0] segment_size;
  logic [38:0] rate_bps;
  logic [31:0] window;
  logic [63:0] last_dec;
  logic [31:0] next_seq;
  logic        pending;

  bwc_pkg::state_t state, state_next;
  bwc_pkg::in_item_t item;
  bwc_pkg::out_item_t res;

  // Feedback datapath registers
  logic [63:0] rtt;
  logic [63:0] prod_dw;
  logic [63:0] prod_dl_lo;
  logic [38:0] prod_dl_hi;
  logic [71:0] prod_dl;
  logic [48:0] prod_sl;
  logic [63:0] quo;
  logic [63:0] a_bound;
  logic [31:0] target;
  logic [63:0] iv1;
  logic [63:0] iv2;
  logic [bwc_pkg::OP_W-1:0] op;

  // Shared divider
  logic [bwc_pkg::DVD_W-1:0] dvd;
  logic [bwc_pkg::DVS_W-1:0] dvs;
  logic [63:0] rem;
  logic [bwc_pkg::CNT_W-1:0] cnt;
  logic [64:0] rem_sh;
  logic        qbit;
  logic [64:0] rem_sub;
  logic [63:0] q_ceil;

  logic [15:0] sdiv;
  logic [38:0] link;
  logic        last_step;
  logic        last_op;

  logic [32:0] win_sum;
  logic [48:0] NS8_EXT;

  // Per-item result
  logic [31:0] stride;
  logic [63:0] iv_max;
  logic        sent_req;
  logic        fb_dec;
  logic [31:0] win_apply;

  assign sdiv = (segment_size == 16'd0) ? 16'd1 : segment_size;
  assign link = (rate_bps == 39'd0) ? 39'd1 : rate_bps;
  assign win_sum = {1'b0, window} + {17'd0, segment_size};
  assign NS8_EXT = {16'd0, bwc_pkg::NS8};

  // One restoring step
  assign rem_sh    = {rem, dvd[bwc_pkg::DVD_W-1]};
  assign rem_sub   = rem_sh - {1'b0, dvs};
  assign qbit      = !rem_sub[64];
  assign q_ceil    = dvd[63:0] + {63'd0, (rem != 64'd0)};
  assign last_step = (cnt == 7'(bwc_pkg::DVD_W - 1));
  assign last_op   = (op == 3'(bwc_pkg::NOPS - 1));

  // Request, decrease and new window for the held item
  always_comb begin
    stride   = (window > {16'd0, segment_size}) ? window : {16'd0, segment_size};
    iv_max   = (iv1 > iv2) ? iv1 : iv2;
    sent_req = (item.mode == bwc_pkg::MODE_SENT) && (item.segment_bytes != 16'd0) &&
               (!pending || ((item.seq_num - next_seq) < 32'h8000_0000));
    fb_dec   = (item.mode == bwc_pkg::MODE_FEEDBACK) && (item.now_ns >= last_dec) &&
               ((item.now_ns - last_dec) >= iv_max);
    win_apply = window;
    if (fb_dec) begin
      win_apply = ({1'b0, window} >= {16'd0, segment_size, 1'b0}) ?
                  window - {16'd0, segment_size} : {16'd0, segment_size};
    end else if (item.mode == bwc_pkg::MODE_ACK && item.inc_flag) begin
      win_apply = win_sum[32] ? '1 : win_sum[31:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bwc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.mode == bwc_pkg::MODE_FEEDBACK) ? bwc_pkg::S_MUL
                                                                : bwc_pkg::S_APPLY;
        end
      end
      bwc_pkg::S_MUL:   state_next = bwc_pkg::S_MUL2;
      bwc_pkg::S_MUL2:  state_next = bwc_pkg::S_LOAD;
      bwc_pkg::S_LOAD:  state_next = bwc_pkg::S_DIV;
      bwc_pkg::S_DIV: begin
        if (last_step) state_next = bwc_pkg::S_STORE;
      end
      bwc_pkg::S_STORE: state_next = last_op ? bwc_pkg::S_APPLY : bwc_pkg::S_LOAD;
      bwc_pkg::S_APPLY: state_next = bwc_pkg::S_RESP;
      bwc_pkg::S_RESP: begin
        if (!out_valid || out_ready) state_next = bwc_pkg::S_IDLE;
      end
      default:          state_next = bwc_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = (state == bwc_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bwc_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size <= 16'd1448;
      rate_bps     <= 39'd100000000000;
      window       <= 32'd14480;
      last_dec     <= 64'd0;
      next_seq     <= 32'd0;
      pending      <= 1'b0;
      out_valid    <= 1'b0;
      op           <= '0;
      cnt          <= '0;
    end else begin
      // Result taken; a new one may be loaded below in the respond state
      if (out_valid && out_ready && state != bwc_pkg::S_RESP) out_valid <= 1'b0;

      // Configuration writes must arrive only while idle; the block itself does not enforce this
      if (wr_en) begin
        case (wr_index)
          bwc_pkg::REG_SEGMENT_SIZE:   segment_size <= wr_data[15:0];
          bwc_pkg::REG_BIT_RATE:       rate_bps     <= wr_data[38:0];
          bwc_pkg::REG_INITIAL_WINDOW: window       <= wr_data[31:0];
          default: ;
        endcase
      end

      case (state)
        bwc_pkg::S_IDLE: begin
          item <= in_data;
          op   <= '0;
        end
        bwc_pkg::S_MUL: begin
          rtt        <= (item.now_ns > item.tx_stamp_ns) ?
                        item.now_ns - item.tx_stamp_ns : 64'd1;
          prod_dw    <= item.drain_time_ns * window;
          prod_dl_lo <= item.drain_time_ns * link[31:0];
          prod_dl_hi <= item.drain_time_ns * link[38:32];
        end
        bwc_pkg::S_MUL2: begin
          prod_dl <= {8'd0, prod_dl_lo} + {1'b0, prod_dl_hi, 32'd0};
          prod_sl <= segment_size * NS8_EXT;
        end
        bwc_pkg::S_LOAD: begin
          cnt <= '0;
          rem <= '0;
          case (op)
            bwc_pkg::OP_DW_S:    begin dvd <= {8'd0, prod_dw}; dvs <= {48'd0, sdiv}; end
            bwc_pkg::OP_Q_RTT:   begin dvd <= {8'd0, quo};     dvs <= rtt; end
            bwc_pkg::OP_DL_NS:   begin dvd <= prod_dl;         dvs <= {31'd0, bwc_pkg::NS8}; end
            bwc_pkg::OP_Q_S:     begin dvd <= {8'd0, quo};     dvs <= {48'd0, sdiv}; end
            bwc_pkg::OP_RTT_T:   begin dvd <= {8'd0, rtt};     dvs <= {32'd0, target}; end
            default:             begin dvd <= {23'd0, prod_sl}; dvs <= {25'd0, link}; end
          endcase
        end
        bwc_pkg::S_DIV: begin
          cnt <= cnt + 7'd1;
          dvd <= {dvd[bwc_pkg::DVD_W-2:0], qbit};
          rem <= qbit ? rem_sub[63:0] : rem_sh[63:0];
        end
        bwc_pkg::S_STORE: begin
          op <= op + 3'd1;
          case (op)
            bwc_pkg::OP_DW_S:  quo <= q_ceil;
            bwc_pkg::OP_Q_RTT: a_bound <= q_ceil;
            bwc_pkg::OP_DL_NS: quo <= q_ceil;
            bwc_pkg::OP_Q_S: begin
              // target = clamp(min(a, b), 1, 2^32-1)
              if (a_bound == 64'd0 || q_ceil == 64'd0)            target <= 32'd1;
              else if (a_bound[63:32] != 32'd0 && q_ceil[63:32] != 32'd0)
                                                                  target <= '1;
              else if (a_bound < q_ceil)                          target <= a_bound[31:0];
              else                                                target <= q_ceil[31:0];
            end
            bwc_pkg::OP_RTT_T: iv1 <= dvd[63:0];
            default:           iv2 <= dvd[63:0];
          endcase
        end
        bwc_pkg::S_APPLY: begin
          res    <= '{request_inc: sent_req, window_bytes: win_apply, decreased: fb_dec};
          window <= win_apply;
          if (sent_req) begin
            next_seq <= item.seq_num + stride;
            pending  <= 1'b1;
          end
          if (fb_dec) last_dec <= item.now_ns;
        end
        bwc_pkg::S_RESP: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  `BWC_ASSERT_IMPL(a_busy_not_ready, clk, rst, state != bwc_pkg::S_IDLE, !in_ready,
                   "ready while busy")
  `BWC_ASSERT_NEXT(a_div_ends, clk, rst, state == bwc_pkg::S_DIV && last_step,
                   state == bwc_pkg::S_STORE, "divider did not finish")
  `BWC_ASSERT_IMPL(a_one_flag, clk, rst, out_valid, !(out_data.decreased && out_data.request_inc),
                   "decrease and request in one result")

endmodule
